### rtl/core/nru_pkg.sv
// Shared constants and types for the not-recently-used page replacement block.
package nru_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;
	localparam int IDX_W     = $clog2(FRAMES);
	localparam int CNT_W     = $clog2(FRAMES + 1);

	localparam logic [3:0] FRAMES_RESET = 4'd8;

	localparam logic ACT_ACCESS = 1'b0;
	localparam logic ACT_WRITE  = 1'b1;

	// Search token handed from cell to cell.
	typedef struct packed {
		logic                 vld;
		logic [PAGE_BITS-1:0] page;
		logic                 found;     // first empty or matching frame seen
		logic                 fill;      // that frame was empty
		logic [IDX_W-1:0]     slot;
		logic                 best_vld;
		logic [1:0]           best_cls;  // ref*2 + mod of best victim so far
		logic [IDX_W-1:0]     best_slot;
	} scan_t;

	// Broadcast updates from the controller to the row of cells.
	typedef struct packed {
		logic                 page_en;
		logic [IDX_W-1:0]     page_slot;
		logic [PAGE_BITS-1:0] page;
		logic                 bits_en;
		logic [IDX_W-1:0]     bits_slot;
		logic                 ref_bit;
		logic                 mod_bit;
	} commit_t;

endpackage

### rtl/core/nru_page_replacement.sv
// Top level of the not-recently-used page replacement block: controller and frame row.
//
//  channel   direction  signals                     moves
//  --------  ---------  --------------------------  -------------------------------
//  s_axis    in         s_tvalid/s_tready/s_tdata   one access or bit-write request
//                       s_tuser                     request kind (action)
//  m_axis    out        m_tvalid/m_tready/m_tdata   one result per request
//  cfg       in         cfg_valid/cfg_ready/cfg_data frames_in_use register
//
// An access request walks the row of frame cells one cell per cycle. Its result is loaded
// into its own result register at the end of the walk, then into the output register, and
// the next request is taken once the block is back in idle. A bit write loads its result
// register on acceptance and then moves it into the output register.
// Reset clears the valid, reference and modified bits, the fault counter, and sets
// frames_in_use to 8. A stalled output holds its result; a request taken meanwhile still
// runs, then waits in its own result register, and no further request is taken until that
// result moves into the output register.
module nru_page_replacement
	import nru_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] page_number, [18:16] frame_slot,
	                               // [19] ref_value, [20] mod_value, [23:21] zero
	input  logic [0:0]  s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [0] hit, [1] fault, [4:2] placed_slot,
	                               // [36:5] fault_total, [39:37] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	typedef struct packed {
		logic        hit;
		logic        fault;
		logic [2:0]  slot;
		logic [31:0] total;
	} result_t;

	state_t           state_q;
	logic [3:0]       frames_q;
	logic [31:0]      fault_q;
	result_t          res_q;
	logic             m_tvalid_q;
	result_t          m_res_q;

	logic [CNT_W-1:0] active_n;
	logic             accept;
	logic             out_free;
	logic [15:0]      in_page;
	logic [2:0]       in_slot;
	logic             in_act;
	scan_t            tok_head;
	scan_t            tok [FRAMES+1];
	scan_t            last;
	commit_t          commit;
	logic             scan_done;
	logic             sc_fault;
	logic             sc_hit;
	logic [IDX_W-1:0] sc_slot;
	logic [31:0]      fault_nxt;

	assign in_page = s_tdata[15:0];
	assign in_slot = s_tdata[18:16];
	assign in_act  = s_tuser[0];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	// Clamp the frame count: zero acts as one, and anything past the table as FRAMES.
	always_comb begin
		if (frames_q == 4'd0) begin
			active_n = CNT_W'(1);
		end else if (32'(frames_q) > FRAMES) begin
			active_n = CNT_W'(FRAMES);
		end else begin
			active_n = CNT_W'(frames_q);
		end
	end

	// Launch a fresh search token into the first cell for each access request.
	always_comb begin
		tok_head      = '0;
		tok_head.vld  = accept && (in_act == ACT_ACCESS);
		tok_head.page = PAGE_BITS'(in_page);
	end

	assign tok[0] = tok_head;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		nru_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.active_n (active_n),
			.commit   (commit),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	assign last      = tok[FRAMES];
	assign scan_done = last.vld;

	// First empty-or-matching frame wins; with none, evict the lowest-class frame.
	always_comb begin
		if (last.found) begin
			sc_slot  = last.slot;
			sc_hit   = !last.fill;
			sc_fault = last.fill;
		end else begin
			sc_slot  = last.best_slot;
			sc_hit   = 1'b0;
			sc_fault = 1'b1;
		end
	end

	assign fault_nxt = (sc_fault && (fault_q != '1)) ? fault_q + 32'd1 : fault_q;

	// Page fill at scan end; reference/modified write on acceptance of a bit write.
	always_comb begin
		commit           = '0;
		commit.page_en   = scan_done && sc_fault;
		commit.page_slot = sc_slot;
		commit.page      = last.page;
		commit.bits_en   = accept && (in_act == ACT_WRITE) && (32'(in_slot) < FRAMES);
		commit.bits_slot = IDX_W'(in_slot);
		commit.ref_bit   = s_tdata[19];
		commit.mod_bit   = s_tdata[20];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			frames_q   <= FRAMES_RESET;
			fault_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frames_q <= cfg_data;
			end
			// Load a new result once the output register drains, else drop the taken one.
			if ((state_q == ST_HOLD) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (in_act == ACT_WRITE) ? ST_HOLD : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						fault_q <= fault_nxt;
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					// Hand the result over once the output register drains.
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (in_act == ACT_WRITE)) begin
			res_q.hit   <= 1'b0;
			res_q.fault <= 1'b0;
			res_q.slot  <= in_slot;
			res_q.total <= fault_q;
		end else if ((state_q == ST_SCAN) && scan_done) begin
			res_q.hit   <= sc_hit;
			res_q.fault <= sc_fault;
			res_q.slot  <= 3'(sc_slot);
			res_q.total <= fault_nxt;
		end
		if ((state_q == ST_HOLD) && out_free) begin
			m_res_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_res_q.total, m_res_q.slot, m_res_q.fault, m_res_q.hit};

endmodule

### rtl/core/nru_cell.sv
// One frame of the table: holds its page and bits and advances the search token.
module nru_cell
	import nru_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic [CNT_W-1:0] active_n,
	input  commit_t          commit,
	input  scan_t            tok_in,
	output scan_t            tok_out
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic                 ref_q;
	logic                 mod_q;
	scan_t                tok_q;

	logic                 in_rng;
	logic                 take;
	logic                 better;
	logic [1:0]           cls;
	scan_t                tok_nxt;

	assign in_rng = CNT_W'(cell_idx) < active_n;
	assign cls    = {ref_q, mod_q};
	assign take   = tok_in.vld && in_rng && !tok_in.found &&
	                (!valid_q || (page_q == tok_in.page));
	assign better = in_rng && (!tok_in.best_vld || (cls < tok_in.best_cls));

	always_comb begin
		tok_nxt = tok_in;
		if (take) begin
			tok_nxt.found = 1'b1;
			tok_nxt.fill  = !valid_q;
			tok_nxt.slot  = cell_idx;
		end
		if (better) begin
			tok_nxt.best_vld  = 1'b1;
			tok_nxt.best_cls  = cls;
			tok_nxt.best_slot = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			valid_q <= 1'b0;
			ref_q   <= 1'b0;
			mod_q   <= 1'b0;
		end else begin
			tok_q <= tok_nxt;
			if (commit.page_en && (commit.page_slot == cell_idx)) begin
				valid_q <= 1'b1;
			end
			if (commit.bits_en && (commit.bits_slot == cell_idx)) begin
				ref_q <= commit.ref_bit;
				mod_q <= commit.mod_bit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit.page_en && (commit.page_slot == cell_idx)) begin
			page_q <= commit.page;
		end
	end

	assign tok_out = tok_q;

endmodule

### sim/tb.sv
// Self-checking testbench for the not-recently-used page replacement block.
module tb;
	import nru_pkg::*;

	localparam int unsigned QUIET_LIMIT  = 5000; // cycles with no handshake at all
	localparam int unsigned SETTLE_CYCLS = 2 * (FRAMES + 2);
	localparam int unsigned PRESSURE_LEN = 400;
	localparam int unsigned PHASE_ITEMS  = 145;

	typedef struct packed {
		logic                 action;
		logic [PAGE_BITS-1:0] page;
		logic [IDX_W-1:0]     slot;
		logic                 ref_bit;
		logic                 mod_bit;
	} nru_req_t;

	typedef struct packed {
		logic             hit;
		logic             fault;
		logic [IDX_W-1:0] slot;
		logic [31:0]      total;
	} nru_res_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_SPARSE} sink_mode_e;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // [15:0] page_number, [18:16] frame_slot,
	                               // [19] ref_value, [20] mod_value, [23:21] zero
	logic [0:0]  s_tuser   = '0;   // [0] action
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;          // [0] hit, [1] fault, [4:2] placed_slot,
	                               // [36:5] fault_total, [39:37] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data  = '0;

	nru_page_replacement i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the frame table, kept in step with accepted requests.
	logic [PAGE_BITS-1:0] page_tab  [FRAMES];
	logic                 valid_tab [FRAMES];
	logic                 ref_tab   [FRAMES];
	logic                 mod_tab   [FRAMES];
	logic [31:0]          fault_tally  = '0;
	logic [3:0]           frames_cfg   = FRAMES_RESET;

	nru_req_t    pending_reqs[$];    // requests waiting to be offered
	nru_res_t    placements_due[$];  // results owed by the block, oldest first
	int unsigned mismatch_count = 0;
	int unsigned results_seen   = 0;

	function void flag_failure(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] MISMATCH %s", $time, what);
	endfunction

	// Resolve one accepted request against the shadow table and queue its result.
	function void resolve_request(nru_req_t req);
		nru_res_t    res;
		int unsigned span;
		int unsigned j;
		int unsigned best_cls;
		int unsigned cls;
		logic        done;
		res  = '0;
		done = 1'b0;
		if (req.action == ACT_WRITE) begin
			ref_tab[req.slot] = req.ref_bit;
			mod_tab[req.slot] = req.mod_bit;
			res.slot = req.slot;
		end else begin
			// clamp the register to 1..FRAMES
			span = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : frames_cfg;
			for (j = 0; j < span && !done; j++) begin
				if (!valid_tab[j]) begin
					page_tab[j]  = req.page;
					valid_tab[j] = 1'b1;
					res.fault    = 1'b1;
					res.slot     = j[IDX_W-1:0];
					done         = 1'b1;
				end else if (page_tab[j] == req.page) begin
					res.hit  = 1'b1;
					res.slot = j[IDX_W-1:0];
					done     = 1'b1;
				end
			end
			if (!done) begin
				// evict lowest class, lowest index on a tie
				best_cls = 4;
				for (j = 0; j < span; j++) begin
					cls = 32'({ref_tab[j], mod_tab[j]});
					if (cls < best_cls) begin
						best_cls = cls;
						res.slot = j[IDX_W-1:0];
					end
				end
				page_tab[res.slot]  = req.page;
				valid_tab[res.slot] = 1'b1;
				res.fault           = 1'b1;
			end
			if (res.fault && fault_tally != 32'hFFFF_FFFF)
				fault_tally++;
		end
		res.total = fault_tally;
		placements_due.push_back(res);
	endfunction

	// Request driver: bursts of back-to-back requests separated by random gaps.
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk) begin : request_driver
		logic     offer;
		nru_req_t req;
		offer = s_tvalid;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				resolve_request(pending_reqs.pop_front());
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					req = pending_reqs[0];
					s_tdata <= {3'b000, req.mod_bit, req.ref_bit, req.slot, req.page};
					s_tuser <= req.action;
					offer = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// long bursts now and then give stretches with no idling
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
						                                         : $urandom_range(0, 12);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
					end
				end
			end
		end
		s_tvalid <= offer;
	end

	// Result sink: switch between stall patterns; once, hold off for a long
	// stretch so the block backs up and stops taking requests.
	sink_mode_e  sink_mode     = SINK_OPEN;
	int unsigned sink_left     = 0;
	int unsigned hold_left     = 0;
	logic        pressure_done = 1'b0;

	always @(posedge clk) begin : result_sink
		logic take;
		take = 1'b0;
		if (arst_n) begin
			if (!pressure_done && results_seen >= 300) begin
				hold_left     = PRESSURE_LEN;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
			end else begin
				if (sink_left == 0) begin
					sink_mode = sink_mode_e'($urandom_range(0, 2));
					sink_left = $urandom_range(10, 80);
				end else begin
					sink_left--;
				end
				case (sink_mode)
					SINK_OPEN: take = 1'b1;
					SINK_HALF: take = 1'($urandom_range(0, 1));
					default:   take = ($urandom_range(0, 7) != 0);
				endcase
			end
		end
		m_tready <= take;
	end

	// Result monitor: check every accepted result against the oldest one owed.
	always @(posedge clk) begin : result_monitor
		nru_res_t want;
		nru_res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.hit   = m_tdata[0];
			got.fault = m_tdata[1];
			got.slot  = m_tdata[4:2];
			got.total = m_tdata[36:5];
			if (placements_due.size() == 0) begin
				flag_failure($sformatf("unexpected result hit=%0b fault=%0b slot=%0d total=%0d",
					got.hit, got.fault, got.slot, got.total));
			end else begin
				want = placements_due.pop_front();
				if (got.hit !== want.hit || got.fault !== want.fault ||
				    got.slot !== want.slot || got.total !== want.total)
					flag_failure($sformatf(
						"exp hit=%0b fault=%0b slot=%0d total=%0d, got hit=%0b fault=%0b slot=%0d total=%0d",
						want.hit, want.fault, want.slot, want.total,
						got.hit, got.fault, got.slot, got.total));
			end
			results_seen <= results_seen + 1;
		end
	end

	// Watchdog: end the run when no channel has moved for too long.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function void add_access(logic [PAGE_BITS-1:0] page);
		nru_req_t req;
		req.action  = ACT_ACCESS;
		req.page    = page;
		// unused fields carry noise
		req.slot    = IDX_W'($urandom_range(0, FRAMES - 1));
		req.ref_bit = 1'($urandom_range(0, 1));
		req.mod_bit = 1'($urandom_range(0, 1));
		pending_reqs.push_back(req);
	endfunction

	function void add_write(logic [IDX_W-1:0] slot, logic ref_bit, logic mod_bit);
		nru_req_t req;
		req.action  = ACT_WRITE;
		req.page    = PAGE_BITS'($urandom_range(0, 65535));
		req.slot    = slot;
		req.ref_bit = ref_bit;
		req.mod_bit = mod_bit;
		pending_reqs.push_back(req);
	endfunction

	// Wait until every request is taken and every result is back, then let
	// the block settle before touching the register.
	task automatic drain();
		while (pending_reqs.size() > 0 || placements_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLS) @(posedge clk);
	endtask

	task automatic set_frames(logic [3:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		frames_cfg  = value;
	endtask

	// Mostly a small working set of pages so hits and evictions both happen,
	// with random pages and bit writes mixed in.
	task automatic add_random_phase(int unsigned count, int unsigned span);
		logic [PAGE_BITS-1:0] pool [16];
		int unsigned          pool_size;
		int unsigned          k;
		int unsigned          pick;
		pool_size = span + $urandom_range(1, 5);
		for (k = 0; k < pool_size; k++)
			pool[k] = PAGE_BITS'($urandom_range(0, 65535));
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				add_write(IDX_W'($urandom_range(0, FRAMES - 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			else if (pick < 28)
				add_access(PAGE_BITS'($urandom_range(0, 65535)));
			else
				add_access(pool[$urandom_range(0, pool_size - 1)]);
		end
	endtask

	initial begin : stimulus
		logic [3:0]  phase_cfg [10];
		int unsigned p;
		int unsigned span;
		for (p = 0; p < FRAMES; p++) begin
			page_tab[p]  = '0;
			valid_tab[p] = 1'b0;
			ref_tab[p]   = 1'b0;
			mod_tab[p]   = 1'b0;
		end
		phase_cfg = '{4'd3, 4'd15, 4'd1, 4'd0, 4'd8, 4'd5, 4'd2, 4'd7, 4'd15, 4'd4};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset frame count.
		add_access(16'h0000);            // fill frame 0
		add_access(16'hFFFF);            // fill frame 1
		add_access(16'h0000);            // hit frame 0
		add_write(3'd7, 1'b1, 1'b1);     // bits of a frame still empty
		for (p = 1; p <= 6; p++)
			add_access(PAGE_BITS'(16'h1111 * p));    // fill frames 2..7
		add_access(16'hFFFF);            // hit frame 1
		add_write(3'd0, 1'b1, 1'b1);
		add_write(3'd1, 1'b1, 1'b0);
		add_write(3'd2, 1'b0, 1'b1);
		add_write(3'd3, 1'b1, 1'b1);
		add_write(3'd4, 1'b1, 1'b1);
		add_write(3'd5, 1'b1, 1'b1);
		add_write(3'd6, 1'b1, 1'b1);
		add_access(16'hABCD);            // evict frame 2, only modified
		add_write(3'd2, 1'b1, 1'b1);
		add_access(16'h5A5A);            // evict frame 1, only referenced
		add_write(3'd7, 1'b0, 1'b0);
		add_access(16'h0F0F);            // evict frame 7, class zero
		drain();

		// Random phases over several frame counts; shrinking the count leaves
		// the upper frames resident for later phases to find again.
		for (p = 0; p < 10; p++) begin
			set_frames(phase_cfg[p]);
			span = (phase_cfg[p] == 0) ? 1 : (phase_cfg[p] > FRAMES) ? FRAMES : phase_cfg[p];
			add_random_phase(PHASE_ITEMS, span);
			drain();
		end

		if (mismatch_count == 0 && placements_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
